/* hw/rtl/utf8_to_utf16_or_utf32_decoder_top_defines.svh */
// Assertion macros used by the checker file of the decoder.
`ifndef UTF8_TO_UTF16_OR_UTF32_DECODER_TOP_DEFINES_SVH
`define UTF8_TO_UTF16_OR_UTF32_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define U8D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/u8d_pkg.sv */
package u8d_pkg;

	localparam int ByteW      = 8;
	localparam int AccW       = 32;
	localparam int CodeUnitW  = 21;
	localparam int QueueDepth = 4;

	localparam logic [AccW-1:0]      MaxCodePoint = 32'h0010_FFFF;
	localparam logic [AccW-1:0]      MaxBmp       = 32'h0000_FFFF;
	localparam logic [AccW-1:0]      SurrFirst    = 32'h0000_D800;
	localparam logic [AccW-1:0]      SurrEnd      = 32'h0000_E000;
	localparam logic [15:0]          HighSurrBase = 16'hD800;
	localparam logic [15:0]          LowSurrBase  = 16'hDC00;
	localparam logic [10:0]          SuppPlaneOff = 11'h040;

	localparam logic [ByteW-1:0] TermByte  = 8'h00;
	localparam logic [ByteW-1:0] AsciiLast = 8'h7F;
	localparam logic [ByteW-1:0] ContLast  = 8'hBF;
	localparam logic [ByteW-1:0] Lead2Last = 8'hDF;
	localparam logic [ByteW-1:0] Lead3Last = 8'hEF;
	localparam logic [ByteW-1:0] ContMask  = 8'h3F;
	localparam logic [ByteW-1:0] Lead2Mask = 8'h1F;
	localparam logic [ByteW-1:0] Lead3Mask = 8'h0F;
	localparam logic [ByteW-1:0] Lead4Mask = 8'h07;
	localparam logic [1:0]       ContTag   = 2'b10;

	typedef struct packed {
		logic                 pair;
		logic [CodeUnitW-1:0] cp;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* hw/rtl/u8d_byte_if.sv */
interface u8d_byte_if;
	logic                        valid;
	logic                        ready;
	logic [u8d_pkg::ByteW-1:0]   in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
	modport monitor (input valid, input in_byte, input ready);
endinterface

/* hw/rtl/u8d_unit_if.sv */
interface u8d_unit_if;
	logic                            valid;
	logic                            ready;
	logic [u8d_pkg::CodeUnitW-1:0]   code_unit;
	logic                            last_of_run;

	modport source (output valid, output code_unit, output last_of_run, input ready);
	modport sink   (input valid, input code_unit, input last_of_run, output ready);
	modport monitor (input valid, input code_unit, input last_of_run, input ready);
endinterface

/* hw/rtl/u8d_fifo.sv */
module u8d_fifo #(
	parameter int DEPTH = u8d_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8d_pkg::q_entry_t   wdata,
	input  logic                pop,
	output u8d_pkg::q_entry_t   rdata,
	output u8d_pkg::q_status_t  status
);
	import u8d_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	q_entry_t        mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign status.full  = (count_q == FullCnt);
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rdata        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

/* hw/rtl/u8d_front.sv */
module u8d_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               utf16_mode,
	u8d_byte_if.sink           bytes,
	input  u8d_pkg::q_status_t q_status,
	output logic               push,
	output u8d_pkg::q_entry_t  entry
);
	import u8d_pkg::*;

	logic [AccW-1:0]  acc_q;
	logic             pend_q;
	logic [AccW-1:0]  acc_nxt;
	logic             pend_nxt;
	logic             accept;
	logic             flush;
	logic             in_range;
	logic             is_supp;
	logic             is_surr;

	assign bytes.ready = !q_status.full;
	assign accept      = bytes.valid && bytes.ready;

	always_comb begin
		flush    = pend_q && (bytes.in_byte[7:6] != ContTag);
		in_range = (acc_q <= MaxCodePoint);
		is_supp  = (acc_q > MaxBmp);
		is_surr  = (acc_q >= SurrFirst) && (acc_q < SurrEnd);
		push     = accept && flush && in_range && !(utf16_mode && is_surr);
		entry.pair = utf16_mode && is_supp;
		entry.cp   = acc_q[CodeUnitW-1:0];
	end

	always_comb begin
		pend_nxt = 1'b1;
		case (bytes.in_byte) inside
			TermByte: begin
				acc_nxt  = '0;
				pend_nxt = 1'b0;
			end
			[8'h01:AsciiLast]: acc_nxt = {{(AccW-ByteW){1'b0}}, bytes.in_byte};
			[8'h80:ContLast]: acc_nxt = {acc_q[AccW-7:0], bytes.in_byte[5:0]};
			[8'hC0:Lead2Last]: acc_nxt = {{(AccW-ByteW){1'b0}}, bytes.in_byte & Lead2Mask};
			[8'hE0:Lead3Last]: acc_nxt = {{(AccW-ByteW){1'b0}}, bytes.in_byte & Lead3Mask};
			default: acc_nxt = {{(AccW-ByteW){1'b0}}, bytes.in_byte & Lead4Mask};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= 1'b0;
		end else if (accept) begin
			acc_q  <= acc_nxt;
			pend_q <= pend_nxt;
		end
	end
endmodule

/* hw/rtl/u8d_back.sv */
module u8d_back (
	input  logic               clk,
	input  logic               arst_n,
	input  u8d_pkg::q_status_t q_status,
	input  u8d_pkg::q_entry_t  q_rdata,
	output logic               pop,
	u8d_unit_if.source         units
);
	import u8d_pkg::*;

	logic                 valid_q;
	logic [CodeUnitW-1:0] unit_q;
	logic                 last_q;
	logic                 second_q;
	logic [CodeUnitW-1:0] low_q;
	logic                 load;
	logic [10:0]          plane_off;
	logic [15:0]          high_unit;
	logic [15:0]          low_unit;

	assign units.valid       = valid_q;
	assign units.code_unit   = unit_q;
	assign units.last_of_run = last_q;

	always_comb begin
		load      = !valid_q || units.ready;
		pop       = load && !second_q && !q_status.empty;
		plane_off = q_rdata.cp[CodeUnitW-1:10] - SuppPlaneOff;
		high_unit = HighSurrBase + {5'b0, plane_off};
		low_unit  = LowSurrBase | {6'b0, q_rdata.cp[9:0]};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				unit_q <= low_q;
				last_q <= 1'b1;
			end else if (q_rdata.pair) begin
				unit_q <= {{(CodeUnitW-16){1'b0}}, high_unit};
				low_q  <= {{(CodeUnitW-16){1'b0}}, low_unit};
				last_q <= 1'b0;
			end else begin
				unit_q <= q_rdata.cp;
				last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				valid_q  <= 1'b1;
				second_q <= 1'b0;
			end else begin
				valid_q  <= !q_status.empty;
				second_q <= !q_status.empty && q_rdata.pair;
			end
		end
	end
endmodule

/* hw/rtl/utf8_to_utf16_or_utf32_decoder_top.sv */
// Path: a byte that releases a pending code point (the next byte that is not a continuation
// byte, or the terminator) enters the queue as it is transferred, and the back end registers its unit.
// Throughput: one byte per cycle in while the queue has room, one unit per cycle out while the
// receiver is ready; a pair is two units, and the queue between front and back absorbs the extra one.
// Reset (arst_n low, asynchronous): accumulator, pending flag, queue and output valid clear,
// and the mode register returns to UTF-32 output. Bytes stall only while the queue is full.
module utf8_to_utf16_or_utf32_decoder_top #(
	parameter int QUEUE_DEPTH = u8d_pkg::QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	u8d_byte_if.sink   bytes,
	u8d_unit_if.source units
);
	import u8d_pkg::*;

	logic      utf16_q;
	logic      push;
	logic      pop;
	q_entry_t  wdata;
	q_entry_t  rdata;
	q_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf16_q <= 1'b0;
		end else if (cfg_wr_en) begin
			utf16_q <= cfg_wr_data;
		end
	end

	u8d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.utf16_mode (utf16_q),
		.bytes      (bytes),
		.q_status   (status),
		.push       (push),
		.entry      (wdata)
	);

	u8d_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.status (status)
	);

	u8d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (status),
		.q_rdata  (rdata),
		.pop      (pop),
		.units    (units)
	);
endmodule

/* hw/rtl/u8d_checker.sv */
`include "utf8_to_utf16_or_utf32_decoder_top_defines.svh"

module u8d_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          units_valid,
	input logic                          units_ready,
	input logic [u8d_pkg::CodeUnitW-1:0] code_unit,
	input logic                          last_of_run
);
	import u8d_pkg::*;

	logic is_high;
	logic is_low;
	logic in_range;
	logic xfer_high;

	assign is_high   = (code_unit >= CodeUnitW'(HighSurrBase)) &&
		(code_unit < CodeUnitW'(LowSurrBase));
	assign is_low    = (code_unit >= CodeUnitW'(LowSurrBase)) && (code_unit < CodeUnitW'(SurrEnd));
	assign in_range  = (code_unit <= CodeUnitW'(MaxCodePoint));
	assign xfer_high = units_valid && units_ready && !last_of_run;

	// A unit that is not the last of its run is always a high surrogate.
	`U8D_ASSERT_NOW(a_high_surr, units_valid && !last_of_run, is_high, "non-final unit is not a high surrogate")
	// A unit that ends a run never exceeds the Unicode range.
	`U8D_ASSERT_NOW(a_range, units_valid && last_of_run, in_range, "unit above the Unicode range")
	// A stalled unit stays offered.
	`U8D_ASSERT_NEXT(a_hold_valid, units_valid && !units_ready, units_valid, "unit withdrawn before transfer")
	// After a high surrogate is transferred, a low surrogate comes next whenever a unit is offered.
	`U8D_ASSERT_NEXT(a_low_follows, xfer_high, !units_valid || (last_of_run && is_low), "no low surrogate")
endmodule

bind utf8_to_utf16_or_utf32_decoder_top u8d_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.units_valid (units.valid),
	.units_ready (units.ready),
	.code_unit   (units.code_unit),
	.last_of_run (units.last_of_run)
);

/* dv/tb_utf8_to_utf16_or_utf32_decoder_top.sv */
module tb_utf8_to_utf16_or_utf32_decoder_top;
	import u8d_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 10;
	localparam int NUM_PHASES    = 8;
	localparam int RANDOM_BYTES  = 100;
	localparam int NUM_DIRECTED  = 26;

	typedef struct packed {
		logic [CodeUnitW-1:0] code_unit;
		logic                 last_of_run;
	} unit_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	u8d_byte_if byte_bus ();
	u8d_unit_if unit_bus ();

	utf8_to_utf16_or_utf32_decoder_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.bytes      (byte_bus.sink),
		.units      (unit_bus.source)
	);

	logic [ByteW-1:0] pending_bytes [$];
	unit_t            units_due [$];

	logic [AccW-1:0] code_point_acc;
	logic            code_point_open;
	logic            utf16_mode;

	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int cycle_count;

	int idle_send_table [4] = '{0, 54, 0, 34};
	int idle_recv_table [4] = '{0, 0, 54, 34};

	logic [ByteW-1:0] directed_bytes [NUM_DIRECTED] = '{
		8'h00, 8'h7F, 8'hC2, 8'h80, 8'hED, 8'hA0, 8'h80,
		8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
		8'hF4, 8'h90, 8'h80, 8'h80, 8'hC0, 8'h80,
		8'h00, 8'h80, 8'hBF, 8'hFF, 8'h00
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
		error_count++;
	endtask

	function automatic void push_unit(logic [31:0] value, logic last);
		unit_t u;
		u.code_unit   = value[CodeUnitW-1:0];
		u.last_of_run = last;
		units_due.push_back(u);
	endfunction

	function automatic void decode_byte(logic [ByteW-1:0] b);
		logic [AccW-1:0] cp;
		logic [AccW-1:0] offset;
		cp = code_point_acc;
		if (code_point_open && b[7:6] != ContTag && cp <= MaxCodePoint) begin
			if (!utf16_mode) begin
				push_unit(cp, 1'b1);
			end else if (cp > MaxBmp) begin
				offset = cp - (MaxBmp + 1);
				push_unit({16'b0, HighSurrBase + 16'(offset >> 10)}, 1'b0);
				push_unit({16'b0, LowSurrBase + {6'b0, cp[9:0]}}, 1'b1);
			end else if (cp < SurrFirst || cp >= SurrEnd) begin
				push_unit(cp, 1'b1);
			end
		end
		if (b == TermByte) begin
			code_point_acc  = '0;
			code_point_open = 1'b0;
		end else begin
			if (b <= AsciiLast) begin
				code_point_acc = {24'b0, b};
			end else if (b <= ContLast) begin
				code_point_acc = {code_point_acc[AccW-7:0], b[5:0]};
			end else if (b <= Lead2Last) begin
				code_point_acc = {24'b0, b & Lead2Mask};
			end else if (b <= Lead3Last) begin
				code_point_acc = {24'b0, b & Lead3Mask};
			end else begin
				code_point_acc = {24'b0, b & Lead4Mask};
			end
			code_point_open = 1'b1;
		end
	endfunction

	// The byte at the head of the queue stays on the bus until its transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_bus.valid <= 1'b0;
		end else begin
			if (byte_bus.valid && byte_bus.ready) begin
				decode_byte(byte_bus.in_byte);
				pending_bytes.delete(0);
			end
			if (!byte_bus.valid || byte_bus.ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					byte_bus.valid   <= 1'b1;
					byte_bus.in_byte <= pending_bytes[0];
				end else begin
					byte_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : unit_monitor
		unit_t due;
		if (!arst_n) begin
			unit_bus.ready <= 1'b0;
		end else begin
			if (unit_bus.valid && unit_bus.ready) begin
				if (units_due.size() == 0) begin
					report_mismatch("unexpected code_unit", 32'(unit_bus.code_unit), 32'h0);
				end else begin
					due = units_due.pop_front();
					if (unit_bus.code_unit !== due.code_unit)
						report_mismatch("code_unit", 32'(unit_bus.code_unit),
							32'(due.code_unit));
					if (unit_bus.last_of_run !== due.last_of_run)
						report_mismatch("last_of_run", 32'(unit_bus.last_of_run),
							32'(due.last_of_run));
				end
			end
			unit_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		int count;
		int kind;
		int seq_len;
		int conts;
		logic [ByteW-1:0] lead;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = 1'b0;
		byte_bus.valid   = 1'b0;
		byte_bus.in_byte = '0;
		unit_bus.ready   = 1'b0;
		code_point_acc   = '0;
		code_point_open  = 1'b0;
		utf16_mode       = 1'b0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		error_count      = 0;
		cycle_count      = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			@(posedge clk);
			cfg_wr_en   <= 1'b1;
			cfg_wr_data <= phase[0];
			utf16_mode   = phase[0];
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			send_idle_pct  = idle_send_table[phase / 2];
			recv_stall_pct = idle_recv_table[phase / 2];

			if (phase < 2) begin
				foreach (directed_bytes[i])
					pending_bytes.push_back(directed_bytes[i]);
			end

			// Mostly well-formed characters, with terminators, noise and broken sequences.
			count = 0;
			while (count < RANDOM_BYTES) begin
				kind = $urandom_range(99);
				if (kind < 5) begin
					pending_bytes.push_back(TermByte);
					count++;
				end else if (kind < 20) begin
					pending_bytes.push_back(8'($urandom_range(255)));
					count++;
				end else begin
					seq_len = $urandom_range(4, 1);
					case (seq_len)
						1: lead = 8'($urandom_range(127, 1));
						2: lead = 8'hC0 | 8'($urandom_range(31));
						3: lead = 8'hE0 | 8'($urandom_range(15));
						default: lead = 8'hF0 | 8'($urandom_range(7));
					endcase
					conts = seq_len - 1;
					if (kind < 30)
						conts = $urandom_range(4);
					pending_bytes.push_back(lead);
					for (int k = 0; k < conts; k++)
						pending_bytes.push_back(8'h80 | 8'($urandom_range(63)));
					count += 1 + conts;
				end
			end

			while (pending_bytes.size() != 0 || byte_bus.valid || units_due.size() != 0)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

/* utf8_to_utf16_or_utf32_decoder_top.f */
+incdir+hw/rtl
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_byte_if.sv
hw/rtl/u8d_unit_if.sv
hw/rtl/u8d_fifo.sv
hw/rtl/u8d_front.sv
hw/rtl/u8d_back.sv
hw/rtl/utf8_to_utf16_or_utf32_decoder_top.sv
hw/rtl/u8d_checker.sv
dv/tb_utf8_to_utf16_or_utf32_decoder_top.sv
